/* rtl/rctgm_pkg.sv */
// Package for the throttle and gear mapper: word types, control word format and microcode.
package rctgm_pkg;

  typedef struct packed {
    logic              connected;
    logic [7:0]        throttle;
    logic [7:0]        brake;
    logic signed [7:0] stick_x;
    logic              nitro;
    logic              square_pressed;
    logic              up_pressed;
    logic              down_pressed;
  } in_word_t;

  typedef struct packed {
    logic [11:0]       esc_pulse;
    logic [7:0]        servo_angle;
    logic signed [7:0] net_speed;
    logic [2:0]        gear_now;
    logic              ignition_on;
  } out_word_t;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned PulseW    = 12;
  localparam int unsigned StepW     = 5;
  localparam int unsigned AccW      = 19;
  localparam int unsigned ProdW     = 32;

  localparam logic [CfgIdxW-1:0] REG_NEUTRAL = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_FWD_MIN = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_FWD_MAX = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_REV_MIN = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_REV_MAX = 3'd4;

  localparam logic [PulseW-1:0] RST_NEUTRAL = 12'd1500;
  localparam logic [PulseW-1:0] RST_FWD_MIN = 12'd1570;
  localparam logic [PulseW-1:0] RST_FWD_MAX = 12'd1650;
  localparam logic [PulseW-1:0] RST_REV_MIN = 12'd1350;
  localparam logic [PulseW-1:0] RST_REV_MAX = 12'd1250;

  localparam logic [2:0] GEAR_TOP = 3'd4;

  // Micro-operations.
  localparam logic [3:0] OP_LOAD  = 4'd0;
  localparam logic [3:0] OP_MUL   = 4'd1;
  localparam logic [3:0] OP_DIVA  = 4'd2;
  localparam logic [3:0] OP_DIVB  = 4'd3;
  localparam logic [3:0] OP_OFFS  = 4'd4;
  localparam logic [3:0] OP_NET   = 4'd5;
  localparam logic [3:0] OP_PULSE = 4'd6;
  localparam logic [3:0] OP_STEER = 4'd7;
  localparam logic [3:0] OP_ANGLE = 4'd8;
  localparam logic [3:0] OP_DISC  = 4'd9;
  localparam logic [3:0] OP_EMIT  = 4'd10;
  localparam logic [3:0] OP_NOP   = 4'd11;

  // Divisor codes.
  localparam logic [3:0] DIV_10   = 4'd0;
  localparam logic [3:0] DIV_4    = 4'd1;
  localparam logic [3:0] DIV_2    = 4'd2;
  localparam logic [3:0] DIV_1    = 4'd3;
  localparam logic [3:0] DIV_5    = 4'd4;
  localparam logic [3:0] DIV_51   = 4'd5;
  localparam logic [3:0] DIV_17   = 4'd6;
  localparam logic [3:0] DIV_99   = 4'd7;
  localparam logic [3:0] DIV_GEAR = 4'd8;

  // Multiplier codes.
  localparam logic [3:0] MUL_GEAR = 4'd0;
  localparam logic [3:0] MUL_7    = 4'd1;
  localparam logic [3:0] MUL_20   = 4'd2;
  localparam logic [3:0] MUL_12   = 4'd3;
  localparam logic [3:0] MUL_SPAN = 4'd4;

  // Jump conditions.
  localparam logic [1:0] CND_NONE     = 2'd0;
  localparam logic [1:0] CND_ALWAYS   = 2'd1;
  localparam logic [1:0] CND_NOCONN   = 2'd2;
  localparam logic [1:0] CND_NONITRO  = 2'd3;

  localparam logic [StepW-1:0] STEP_OFFS = 5'd7;
  localparam logic [StepW-1:0] STEP_DISC = 5'd21;
  localparam logic [StepW-1:0] STEP_EMIT = 5'd22;

  typedef struct packed {
    logic [3:0]       op;
    logic [3:0]       arg;
    logic [1:0]       cond;
    logic [StepW-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic [6:0]  d;
    logic [12:0] r;
    logic [4:0]  k;
  } div_const_t;

  // Reciprocal constants: r = floor(2^k / d), with 2^k above the largest dividend.
  function automatic div_const_t div_const(input logic [3:0] code);
    div_const_t c;
    case (code)
      DIV_10:  c = '{d: 7'd10, r: 13'd6553, k: 5'd16};
      DIV_4:   c = '{d: 7'd4,  r: 13'd4096, k: 5'd14};
      DIV_2:   c = '{d: 7'd2,  r: 13'd4096, k: 5'd13};
      DIV_1:   c = '{d: 7'd1,  r: 13'd4096, k: 5'd12};
      DIV_5:   c = '{d: 7'd5,  r: 13'd6553, k: 5'd15};
      DIV_51:  c = '{d: 7'd51, r: 13'd5140, k: 5'd18};
      DIV_17:  c = '{d: 7'd17, r: 13'd7710, k: 5'd17};
      DIV_99:  c = '{d: 7'd99, r: 13'd5295, k: 5'd19};
      default: c = '{d: 7'd1,  r: 13'd4096, k: 5'd12};
    endcase
    return c;
  endfunction

  function automatic logic [3:0] gear_div(input logic [2:0] gear);
    logic [3:0] code;
    case (gear)
      3'd0:    code = DIV_10;
      3'd1:    code = DIV_4;
      3'd2:    code = DIV_2;
      3'd3:    code = DIV_4;
      default: code = DIV_1;
    endcase
    return code;
  endfunction

  function automatic ctrl_t ucode(input logic [StepW-1:0] step);
    ctrl_t cw;
    case (step)
      5'd0:    cw = '{op: OP_LOAD,  arg: DIV_1,    cond: CND_NOCONN,  target: STEP_DISC};
      5'd1:    cw = '{op: OP_MUL,   arg: MUL_GEAR, cond: CND_NONE,    target: STEP_EMIT};
      5'd2:    cw = '{op: OP_DIVA,  arg: DIV_GEAR, cond: CND_NONE,    target: STEP_EMIT};
      5'd3:    cw = '{op: OP_DIVB,  arg: DIV_GEAR, cond: CND_NONITRO, target: STEP_OFFS};
      5'd4:    cw = '{op: OP_MUL,   arg: MUL_7,    cond: CND_NONE,    target: STEP_EMIT};
      5'd5:    cw = '{op: OP_DIVA,  arg: DIV_5,    cond: CND_NONE,    target: STEP_EMIT};
      5'd6:    cw = '{op: OP_DIVB,  arg: DIV_5,    cond: CND_NONE,    target: STEP_EMIT};
      5'd7:    cw = '{op: OP_OFFS,  arg: DIV_1,    cond: CND_NONE,    target: STEP_EMIT};
      5'd8:    cw = '{op: OP_MUL,   arg: MUL_20,   cond: CND_NONE,    target: STEP_EMIT};
      5'd9:    cw = '{op: OP_DIVA,  arg: DIV_51,   cond: CND_NONE,    target: STEP_EMIT};
      5'd10:   cw = '{op: OP_DIVB,  arg: DIV_51,   cond: CND_NONE,    target: STEP_EMIT};
      5'd11:   cw = '{op: OP_NET,   arg: DIV_1,    cond: CND_NONE,    target: STEP_EMIT};
      5'd12:   cw = '{op: OP_MUL,   arg: MUL_SPAN, cond: CND_NONE,    target: STEP_EMIT};
      5'd13:   cw = '{op: OP_DIVA,  arg: DIV_99,   cond: CND_NONE,    target: STEP_EMIT};
      5'd14:   cw = '{op: OP_DIVB,  arg: DIV_99,   cond: CND_NONE,    target: STEP_EMIT};
      5'd15:   cw = '{op: OP_PULSE, arg: DIV_1,    cond: CND_NONE,    target: STEP_EMIT};
      5'd16:   cw = '{op: OP_STEER, arg: DIV_1,    cond: CND_NONE,    target: STEP_EMIT};
      5'd17:   cw = '{op: OP_MUL,   arg: MUL_12,   cond: CND_NONE,    target: STEP_EMIT};
      5'd18:   cw = '{op: OP_DIVA,  arg: DIV_17,   cond: CND_NONE,    target: STEP_EMIT};
      5'd19:   cw = '{op: OP_DIVB,  arg: DIV_17,   cond: CND_NONE,    target: STEP_EMIT};
      5'd20:   cw = '{op: OP_ANGLE, arg: DIV_1,    cond: CND_ALWAYS,  target: STEP_EMIT};
      5'd21:   cw = '{op: OP_DISC,  arg: DIV_1,    cond: CND_NONE,    target: STEP_EMIT};
      5'd22:   cw = '{op: OP_EMIT,  arg: DIV_1,    cond: CND_NONE,    target: STEP_EMIT};
      default: cw = '{op: OP_NOP,   arg: DIV_1,    cond: CND_ALWAYS,  target: STEP_EMIT};
    endcase
    return cw;
  endfunction

endpackage

/* rtl/rc_throttle_gear_mapper_top.sv */
// Top level of the throttle and gear mapper: microcoded sequencer over a small datapath.
//
// Each accepted controller word runs through a microprogram held in a read-only table: one
// control word per step drives a small datapath with one accumulator, a scaling multiplier and a
// reciprocal divider by constant (multiply, then a compare-and-subtract correction). A word
// runs the program from the load step to the emit step; the nitro steps run only with nitro,
// and a disconnected controller jumps from the load step straight to the disconnect step.
// The next word is accepted once the current result has moved to the output register,
// which holds it until the receiver takes it. Configuration writes are always ready.
module rc_throttle_gear_mapper_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rctgm_pkg::in_word_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rctgm_pkg::out_word_t                out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rctgm_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [rctgm_pkg::PulseW-1:0]        cfg_data
);

  localparam int unsigned AccW  = rctgm_pkg::AccW;
  localparam int unsigned ProdW = rctgm_pkg::ProdW;
  localparam int unsigned PW    = rctgm_pkg::PulseW;

  logic [PW-1:0]                 neutral_r, fwd_min_r, fwd_max_r, rev_min_r, rev_max_r;
  logic                          busy_r;
  logic [rctgm_pkg::StepW-1:0]   step_r;
  rctgm_pkg::in_word_t           in_r;
  logic [2:0]                    gear_r;
  logic                          ign_r;
  logic [AccW-1:0]               acc_r;
  logic                          neg_r;
  logic [ProdW-1:0]              prod_r;
  logic signed [7:0]             net_r;
  logic                          dir_r;
  logic                          zero_r;
  logic [PW-1:0]                 pulse_r;
  logic [7:0]                    angle_r;
  logic                          out_valid_r;
  rctgm_pkg::out_word_t          out_data_r;

  rctgm_pkg::ctrl_t              ctrl;
  rctgm_pkg::div_const_t         dc;
  logic [3:0]                    dcode;
  logic [PW-1:0]                 span_hi, span_lo;
  logic [PW:0]                   span;
  logic [PW-1:0]                 span_mag;
  logic [PW-1:0]                 mk;
  logic [30:0]                   mul_full;
  logic [ProdW-1:0]              div_full;
  logic [AccW-1:0]               q_est;
  logic [25:0]                   qd;
  logic [AccW:0]                 rem;
  logic [AccW-1:0]               q_fix;
  logic [8:0]                    diff;
  logic [7:0]                    diff_mag;
  logic [7:0]                    clamp_mag;
  logic [8:0]                    offs;
  logic                          jump;
  logic [2:0]                    gear_up, gear_nxt;
  logic                          out_free;

  assign in_stall  = busy_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    ctrl = rctgm_pkg::ucode(step_r);
    if (ctrl.arg == rctgm_pkg::DIV_GEAR) begin
      dcode = rctgm_pkg::gear_div(gear_r);
    end else begin
      dcode = ctrl.arg;
    end
    dc = rctgm_pkg::div_const(dcode);

    span_hi  = dir_r ? fwd_max_r : rev_max_r;
    span_lo  = dir_r ? fwd_min_r : rev_min_r;
    span     = {1'b0, span_hi} - {1'b0, span_lo};
    span_mag = span[PW] ? PW'(-span) : span[PW-1:0];

    case (ctrl.arg)
      rctgm_pkg::MUL_GEAR: mk = (gear_r == 3'd3) ? PW'(3) : PW'(1);
      rctgm_pkg::MUL_7:    mk = PW'(7);
      rctgm_pkg::MUL_20:   mk = PW'(20);
      rctgm_pkg::MUL_12:   mk = PW'(12);
      rctgm_pkg::MUL_SPAN: mk = span_mag;
      default:             mk = PW'(1);
    endcase
    mul_full = 31'(acc_r) * 31'(mk);
    div_full = ProdW'(acc_r) * ProdW'(dc.r);

    q_est = AccW'(prod_r >> dc.k);
    qd    = 26'(q_est) * 26'(dc.d);
    rem   = {1'b0, acc_r} - qd[AccW:0];
    q_fix = (rem >= (AccW+1)'(dc.d)) ? q_est + AccW'(1) : q_est;

    diff     = {1'b0, in_r.throttle} - {1'b0, in_r.brake};
    diff_mag = diff[8] ? 8'(-diff) : diff[7:0];

    clamp_mag = (acc_r > AccW'(255)) ? 8'd255 : acc_r[7:0];
    offs      = neg_r ? 9'(9'd255 - {1'b0, clamp_mag}) : 9'(9'd255 + {1'b0, clamp_mag});

    gear_up  = (in_r.up_pressed && gear_r < rctgm_pkg::GEAR_TOP) ? gear_r + 3'd1 : gear_r;
    gear_nxt = (in_r.down_pressed && gear_up > 3'd0) ? gear_up - 3'd1 : gear_up;

    case (ctrl.cond)
      rctgm_pkg::CND_ALWAYS:  jump = 1'b1;
      rctgm_pkg::CND_NOCONN:  jump = !in_r.connected;
      rctgm_pkg::CND_NONITRO: jump = !in_r.nitro;
      default:                jump = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neutral_r <= rctgm_pkg::RST_NEUTRAL;
      fwd_min_r <= rctgm_pkg::RST_FWD_MIN;
      fwd_max_r <= rctgm_pkg::RST_FWD_MAX;
      rev_min_r <= rctgm_pkg::RST_REV_MIN;
      rev_max_r <= rctgm_pkg::RST_REV_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rctgm_pkg::REG_NEUTRAL: neutral_r <= cfg_data;
        rctgm_pkg::REG_FWD_MIN: fwd_min_r <= cfg_data;
        rctgm_pkg::REG_FWD_MAX: fwd_max_r <= cfg_data;
        rctgm_pkg::REG_REV_MIN: rev_min_r <= cfg_data;
        rctgm_pkg::REG_REV_MAX: rev_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      gear_r      <= '0;
      ign_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall &&
          !(busy_r && ctrl.op == rctgm_pkg::OP_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      if (!busy_r) begin
        if (in_valid) begin
          busy_r <= 1'b1;
          step_r <= '0;
        end
      end else if (ctrl.op == rctgm_pkg::OP_EMIT) begin
        if (out_free) begin
          out_valid_r <= 1'b1;
          busy_r      <= 1'b0;
        end
      end else begin
        if (ctrl.op == rctgm_pkg::OP_LOAD && in_r.connected) begin
          gear_r <= gear_nxt;
          ign_r  <= ign_r ^ in_r.square_pressed;
        end
        step_r <= jump ? ctrl.target : step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && in_valid) begin
      in_r <= in_data;
    end
    if (busy_r) begin
      case (ctrl.op)
        rctgm_pkg::OP_LOAD: begin
          acc_r <= AccW'(diff_mag);
          neg_r <= diff[8];
        end
        rctgm_pkg::OP_MUL: begin
          acc_r <= mul_full[AccW-1:0];
          if (ctrl.arg == rctgm_pkg::MUL_SPAN) begin
            neg_r <= span[PW];
          end
        end
        rctgm_pkg::OP_DIVA: begin
          prod_r <= div_full;
        end
        rctgm_pkg::OP_DIVB: begin
          acc_r <= q_fix;
        end
        rctgm_pkg::OP_OFFS: begin
          acc_r <= AccW'(offs);
          neg_r <= 1'b0;
        end
        rctgm_pkg::OP_NET: begin
          net_r  <= acc_r[7:0] - 8'd100;
          dir_r  <= acc_r > AccW'(100);
          zero_r <= acc_r == AccW'(100);
          if (acc_r > AccW'(100)) begin
            acc_r <= acc_r - AccW'(101);
          end else if (acc_r < AccW'(100)) begin
            acc_r <= AccW'(99) - acc_r;
          end else begin
            acc_r <= '0;
          end
        end
        rctgm_pkg::OP_PULSE: begin
          if (ign_r && !zero_r) begin
            pulse_r <= neg_r ? span_lo - acc_r[PW-1:0] : span_lo + acc_r[PW-1:0];
          end else begin
            pulse_r <= neutral_r;
          end
        end
        rctgm_pkg::OP_STEER: begin
          acc_r <= AccW'({~in_r.stick_x[7], in_r.stick_x[6:0]});
        end
        rctgm_pkg::OP_ANGLE: begin
          angle_r <= 8'd180 - acc_r[7:0];
        end
        rctgm_pkg::OP_DISC: begin
          net_r   <= '0;
          pulse_r <= neutral_r;
          angle_r <= 8'd90;
        end
        rctgm_pkg::OP_EMIT: begin
          if (out_free) begin
            out_data_r.esc_pulse   <= pulse_r;
            out_data_r.servo_angle <= angle_r;
            out_data_r.net_speed   <= net_r;
            out_data_r.gear_now    <= gear_r;
            out_data_r.ignition_on <= ign_r;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
